>>> rtl/ckmc_pkg.sv
package ckmc_pkg;

  // image and filter geometry
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MORPH_PASSES = 3;
  localparam int NUM_STAGES   = 2 * MORPH_PASSES;
  localparam int MIN_DIM      = 3;

  // per-stage mask ring, indexed by item count
  localparam int RING_LEN = 2 * MAX_WIDTH + 4;
  localparam int RING_AW  = $clog2(RING_LEN);

  localparam int PIX_W = 8;
  localparam int TOL_W = 9;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = COL_W + 1;
  localparam int HGT_W = ROW_W + 1;
  localparam int CNT_W = 23;
  localparam int DLY_W = $clog2(NUM_STAGES * (MAX_WIDTH + 1) + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // apb register map
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_KEY_BLUE     = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_KEY_GREEN    = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_KEY_RED      = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE    = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = REG_IDX_W'(5);

  // reset values of the registers
  localparam logic [PIX_W-1:0] RST_KEY_BLUE  = 8'd138;
  localparam logic [PIX_W-1:0] RST_KEY_GREEN = 8'd63;
  localparam logic [PIX_W-1:0] RST_KEY_RED   = 8'd23;
  localparam logic [TOL_W-1:0] RST_TOLERANCE = 9'd50;
  localparam logic [WID_W-1:0] RST_WIDTH     = WID_W'(640);
  localparam logic [HGT_W-1:0] RST_HEIGHT    = HGT_W'(480);

  // settings seen by the datapath
  typedef struct packed {
    logic [PIX_W-1:0]                  key_blue;
    logic [PIX_W-1:0]                  key_green;
    logic [PIX_W-1:0]                  key_red;
    logic [TOL_W-1:0]                  tolerance;
    logic [WID_W-1:0]                  width;
    logic [COL_W-1:0]                  wm1;
    logic [ROW_W-1:0]                  hm1;
    logic [CNT_W-1:0]                  npix;
    logic [NUM_STAGES-1:0][DLY_W-1:0]  delay;
  } ckmc_cfg_t;

  // one request travelling down the filter chain
  typedef struct packed {
    logic               val;
    logic               wr_en;
    logic               start;
    logic               last;
    logic               rejected;
    logic [RING_AW-1:0] wa;
    logic [RING_AW-1:0] ra1;
    logic [RING_AW-1:0] ra2;
  } ckmc_item_t;

  function automatic logic [WID_W-1:0] clamp_width(logic [WID_W-1:0] v);
    logic [WID_W-1:0] r;
    if (v < WID_W'(MIN_DIM)) r = WID_W'(MIN_DIM);
    else if (v > WID_W'(MAX_WIDTH)) r = WID_W'(MAX_WIDTH);
    else r = v;
    return r;
  endfunction

  function automatic logic [HGT_W-1:0] clamp_height(logic [HGT_W-1:0] v);
    logic [HGT_W-1:0] r;
    if (v < HGT_W'(MIN_DIM)) r = HGT_W'(MIN_DIM);
    else if (v > HGT_W'(MAX_HEIGHT)) r = HGT_W'(MAX_HEIGHT);
    else r = v;
    return r;
  endfunction

  // items before stage s sees position zero
  function automatic logic [DLY_W-1:0] stage_delay(logic [WID_W-1:0] w, int s);
    logic [DLY_W-1:0] wp1;
    wp1 = DLY_W'(w) + DLY_W'(1);
    return DLY_W'((s + 1) * wp1);
  endfunction

  function automatic logic [CNT_W-1:0] frame_size(logic [WID_W-1:0] w,
                                                  logic [HGT_W-1:0] h);
    logic [WID_W+HGT_W-1:0] p;
    p = w * h;
    return p[CNT_W-1:0];
  endfunction

endpackage

>>> rtl/ckmc_stream_if.sv
interface ckmc_pix_if import ckmc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] red;
  logic             first_pixel;
  logic             flush;

  modport source (output valid, blue, green, red, first_pixel, flush, input ready);
  modport sink   (input valid, blue, green, red, first_pixel, flush, output ready);
endinterface

interface ckmc_res_if import ckmc_pkg::*; ();
  logic valid;
  logic ready;
  logic out_valid;
  logic mask_bit;
  logic frame_last;
  logic rejected;

  modport source (output valid, out_valid, mask_bit, frame_last, rejected, input ready);
  modport sink   (input valid, out_valid, mask_bit, frame_last, rejected, output ready);
endinterface

>>> rtl/color_key_mask_closing_top.sv
// colour key mask with 3x3 closing (three dilations, three erosions)
// pix: one bgr pixel or flush request per handshake, raster order, first_pixel
//   opens a frame; res: one result per request, in order
// each result carries the closed mask bit of the request 6*(width+1) earlier
//   when that is a real pixel (out_valid), frame_last on the frame's final
//   pixel and the sticky border flag in rejected
// apb port sets key colour, tolerance and frame size; sizes are clamped to
//   3..1024 columns and 3..4096 rows
// path from request to result: keyer register, six filter stages and the output
//   register; throughput one request per cycle while res is not stalled, set by
//   each stage's line store doing up to one write and two reads per request
// reset empties the pipeline and restarts frame counting; line store contents
//   are not cleared and are never used before being written in a frame
// when res is stalled the pipeline fills its bubbles and then holds, and
//   pix.ready falls only once every stage and the output register are full
module color_key_mask_closing_top import ckmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  ckmc_pix_if.sink          pix,
  ckmc_res_if.source        res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  ckmc_cfg_t  cfg;
  logic       st_valid [NUM_STAGES+1];
  logic       st_ready [NUM_STAGES+1];
  ckmc_item_t st_item  [NUM_STAGES+1];
  logic       vo;

  ckmc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ckmc_keyer u_keyer (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix       (pix),
    .out_valid (st_valid[0]),
    .out_ready (st_ready[0]),
    .out_item  (st_item[0])
  );

  // dilation stages first, then erosion stages
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    ckmc_morph_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .dilate    ((s < MORPH_PASSES) ? 1'b1 : 1'b0),
      .delay     (cfg.delay[s]),
      .wm1       (cfg.wm1),
      .hm1       (cfg.hm1),
      .in_valid  (st_valid[s]),
      .in_ready  (st_ready[s]),
      .in_item   (st_item[s]),
      .out_valid (st_valid[s+1]),
      .out_ready (st_ready[s+1]),
      .out_item  (st_item[s+1])
    );
  end

  // result register
  assign st_ready[NUM_STAGES] = !vo || res.ready;
  assign res.valid            = vo;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (st_valid[NUM_STAGES] && st_ready[NUM_STAGES]) begin
      vo <= 1'b1;
    end else if (res.ready) begin
      vo <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_valid[NUM_STAGES] && st_ready[NUM_STAGES]) begin
      res.out_valid  <= st_item[NUM_STAGES].wr_en;
      res.mask_bit   <= st_item[NUM_STAGES].val;
      res.frame_last <= st_item[NUM_STAGES].last;
      res.rejected   <= st_item[NUM_STAGES].rejected;
    end
  end

  // input backpressure only comes from a stalled, full output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !pix.ready |-> (res.valid && !res.ready))
    else $error("input stalled without a blocked result");

  // a padding result carries no mask or frame end
  a_pad_result: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.out_valid) |-> (!res.mask_bit && !res.frame_last))
    else $error("mask or frame end on a padding result");

  // clamped width stays inside the line store range
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    (cfg.width >= WID_W'(MIN_DIM)) && (cfg.width <= WID_W'(MAX_WIDTH)))
    else $error("frame width out of range");

endmodule

>>> rtl/ckmc_regs.sv
module ckmc_regs import ckmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output ckmc_cfg_t         cfg
);

  logic [PIX_W-1:0] key_blue, key_green, key_red;
  logic [TOL_W-1:0] tolerance;
  logic [WID_W-1:0] frame_width, width_eff;
  logic [HGT_W-1:0] frame_height, height_eff;
  logic [CNT_W-1:0] npix;
  logic [NUM_STAGES-1:0][DLY_W-1:0] delay;

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;
  logic [WID_W-1:0]     new_w, wm1_full;
  logic [HGT_W-1:0]     new_h, hm1_full;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[APB_AW-1:2];
  assign new_w  = clamp_width(pwdata[WID_W-1:0]);
  assign new_h  = clamp_height(pwdata[HGT_W-1:0]);

  // raw registers plus clamped sizes worked out at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      key_blue     <= RST_KEY_BLUE;
      key_green    <= RST_KEY_GREEN;
      key_red      <= RST_KEY_RED;
      tolerance    <= RST_TOLERANCE;
      frame_width  <= RST_WIDTH;
      frame_height <= RST_HEIGHT;
      width_eff    <= RST_WIDTH;
      height_eff   <= RST_HEIGHT;
      npix         <= frame_size(RST_WIDTH, RST_HEIGHT);
      for (int s = 0; s < NUM_STAGES; s++) delay[s] <= stage_delay(RST_WIDTH, s);
    end else if (wr) begin
      case (idx)
        REG_KEY_BLUE:  key_blue  <= pwdata[PIX_W-1:0];
        REG_KEY_GREEN: key_green <= pwdata[PIX_W-1:0];
        REG_KEY_RED:   key_red   <= pwdata[PIX_W-1:0];
        REG_TOLERANCE: tolerance <= pwdata[TOL_W-1:0];
        REG_FRAME_WIDTH: begin
          frame_width <= pwdata[WID_W-1:0];
          width_eff   <= new_w;
          npix        <= frame_size(new_w, height_eff);
          for (int s = 0; s < NUM_STAGES; s++) delay[s] <= stage_delay(new_w, s);
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= pwdata[HGT_W-1:0];
          height_eff   <= new_h;
          npix         <= frame_size(width_eff, new_h);
        end
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_KEY_BLUE:     prdata = APB_DW'(key_blue);
      REG_KEY_GREEN:    prdata = APB_DW'(key_green);
      REG_KEY_RED:      prdata = APB_DW'(key_red);
      REG_TOLERANCE:    prdata = APB_DW'(tolerance);
      REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height);
      default:          prdata = '0;
    endcase
  end

  assign wm1_full = width_eff - WID_W'(1);
  assign hm1_full = height_eff - HGT_W'(1);

  always_comb begin
    cfg.key_blue  = key_blue;
    cfg.key_green = key_green;
    cfg.key_red   = key_red;
    cfg.tolerance = tolerance;
    cfg.width     = width_eff;
    cfg.wm1       = wm1_full[COL_W-1:0];
    cfg.hm1       = hm1_full[ROW_W-1:0];
    cfg.npix      = npix;
    cfg.delay     = delay;
  end

endmodule

>>> rtl/ckmc_keyer.sv
module ckmc_keyer import ckmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ckmc_cfg_t  cfg,
  ckmc_pix_if.sink   pix,
  output logic       out_valid,
  input  logic       out_ready,
  output ckmc_item_t out_item
);

  logic [CNT_W-1:0]   tcnt, t_e;
  logic [COL_W-1:0]   col, col_e;
  logic [ROW_W-1:0]   row, row_e;
  logic               border, border_e, border_next;
  logic [RING_AW-1:0] wa, ra1, ra2;
  logic               vk, accept, in_frame, keyed, on_border, start;
  ckmc_item_t         item_next;

  function automatic logic chan_close(logic [PIX_W-1:0] p, logic [PIX_W-1:0] k,
                                      logic [TOL_W-1:0] tol);
    logic [PIX_W-1:0] d;
    d = (p >= k) ? p - k : k - p;
    return {1'b0, d} < tol;
  endfunction

  function automatic logic [RING_AW-1:0] ring_back(logic [RING_AW-1:0] a,
                                                   logic [WID_W-1:0] w);
    logic [RING_AW-1:0] wz;
    wz = RING_AW'(w);
    return (a >= wz) ? a - wz : a + RING_AW'(RING_LEN) - wz;
  endfunction

  assign pix.ready = !vk || out_ready;
  assign accept    = pix.valid && pix.ready;

  // frame position, restarted by first_pixel
  assign start    = pix.first_pixel || (tcnt == '0);
  assign t_e      = pix.first_pixel ? '0 : tcnt;
  assign col_e    = pix.first_pixel ? '0 : col;
  assign row_e    = pix.first_pixel ? '0 : row;
  assign border_e = pix.first_pixel ? 1'b0 : border;

  // colour key and border check
  assign in_frame  = t_e < cfg.npix;
  assign keyed     = in_frame && !pix.flush
                     && chan_close(pix.blue,  cfg.key_blue,  cfg.tolerance)
                     && chan_close(pix.green, cfg.key_green, cfg.tolerance)
                     && chan_close(pix.red,   cfg.key_red,   cfg.tolerance);
  assign on_border = (col_e == '0) || (row_e == '0) || (row_e == cfg.hm1)
                     || (col_e == cfg.wm1);
  assign border_next = border_e || (keyed && on_border);

  // ring addresses one and two rows back
  assign ra1 = ring_back(wa, cfg.width);
  assign ra2 = ring_back(ra1, cfg.width);

  always_comb begin
    item_next.val      = keyed;
    item_next.wr_en    = in_frame;
    item_next.start    = start;
    item_next.last     = 1'b0;
    item_next.rejected = border_next;
    item_next.wa       = wa;
    item_next.ra1      = ra1;
    item_next.ra2      = ra2;
  end

  // counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vk     <= 1'b0;
      tcnt   <= '0;
      col    <= '0;
      row    <= '0;
      border <= 1'b0;
      wa     <= '0;
    end else if (accept) begin
      vk     <= 1'b1;
      border <= border_next;
      tcnt   <= (t_e == CNT_MAX) ? t_e : t_e + CNT_W'(1);
      wa     <= (wa == RING_AW'(RING_LEN - 1)) ? '0 : wa + RING_AW'(1);
      if (in_frame) begin
        if (col_e >= cfg.wm1) begin
          col <= '0;
          row <= row_e + ROW_W'(1);
        end else begin
          col <= col_e + COL_W'(1);
          row <= row_e;
        end
      end else begin
        col <= col_e;
        row <= row_e;
      end
    end else if (out_ready) begin
      vk <= 1'b0;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (accept) out_item <= item_next;
  end

  assign out_valid = vk;

endmodule

>>> rtl/ckmc_morph_stage.sv
module ckmc_morph_stage import ckmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             dilate,
  input  logic [DLY_W-1:0] delay,
  input  logic [COL_W-1:0] wm1,
  input  logic [ROW_W-1:0] hm1,
  input  logic             in_valid,
  output logic             in_ready,
  input  ckmc_item_t       in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output ckmc_item_t       out_item
);

  logic ring [RING_LEN];
  logic rd1, rd2;

  logic             vp, pv, c0, cl, r0, rl, plast;
  ckmc_item_t       pitem;
  logic [DLY_W-1:0] dcnt, d_e;
  logic [COL_W-1:0] col, col_e;
  logic [ROW_W-1:0] row, row_e;
  logic             past, past_e;
  logic [2:0]       colm1, col0, newcol, rmask;
  logic             accept, shift, win_or, win_and, win;

  assign in_ready  = !vp || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = vp;
  assign shift     = vp && out_ready;

  // line store: up to one write and two reads per request
  always_ff @(posedge clk) begin
    if (accept && in_item.wr_en) ring[in_item.wa] <= in_item.val;
    if (accept) begin
      rd1 <= ring[in_item.ra1];
      rd2 <= ring[in_item.ra2];
    end
  end

  // position of the window centre for this stage
  assign d_e    = in_item.start ? delay : dcnt;
  assign col_e  = in_item.start ? '0 : col;
  assign row_e  = in_item.start ? '0 : row;
  assign past_e = in_item.start ? 1'b0 : past;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp   <= 1'b0;
      dcnt <= '0;
      col  <= '0;
      row  <= '0;
      past <= 1'b0;
    end else if (accept) begin
      vp <= 1'b1;
      if (d_e != '0) begin
        dcnt <= d_e - DLY_W'(1);
        col  <= col_e;
        row  <= row_e;
        past <= past_e;
      end else begin
        dcnt <= '0;
        col  <= col_e;
        row  <= row_e;
        past <= past_e;
        if (!past_e) begin
          if (col_e == wm1) begin
            col <= '0;
            if (row_e == hm1) past <= 1'b1;
            else row <= row_e + ROW_W'(1);
          end else begin
            col <= col_e + COL_W'(1);
          end
        end
      end
    end else if (out_ready) begin
      vp <= 1'b0;
    end
  end

  // centre flags and request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pitem <= in_item;
      pv    <= (d_e == '0) && !past_e;
      c0    <= col_e == '0;
      cl    <= col_e == wm1;
      r0    <= row_e == '0;
      rl    <= row_e == hm1;
      plast <= (d_e == '0) && !past_e && (col_e == wm1) && (row_e == hm1);
    end
  end

  // window columns: bit 0 row above, bit 1 centre row, bit 2 row below
  always_ff @(posedge clk) begin
    if (shift) begin
      colm1 <= col0;
      col0  <= newcol;
    end
  end

  assign newcol = {pitem.val, rd1, rd2};
  assign rmask  = {!rl, 1'b1, !r0};

  // neighbours outside the image drop out of the window
  assign win_or  = |((colm1 & rmask & {3{!c0}}) | (col0 & rmask)
                     | (newcol & rmask & {3{!cl}}));
  assign win_and = &((colm1 | ~rmask | {3{c0}}) & (col0 | ~rmask)
                     & (newcol | ~rmask | {3{cl}}));
  assign win     = dilate ? win_or : win_and;

  always_comb begin
    out_item       = pitem;
    out_item.val   = pv && win;
    out_item.wr_en = pv;
    out_item.last  = plast;
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
  import ckmc_pkg::*;

  typedef struct {
    bit out_valid;
    bit mask_bit;
    bit frame_last;
    bit rejected;
  } mask_res_t;

  typedef struct {
    bit [PIX_W-1:0] blue;
    bit [PIX_W-1:0] green;
    bit [PIX_W-1:0] red;
    bit             first_pixel;
    bit             flush;
    bit             typed;
    mask_res_t      want;
  } pixel_req_t;

  localparam int IDLE_LIMIT  = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 12;
  localparam int SHOW_ERRORS = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  ckmc_pix_if pix_ch ();
  ckmc_res_if res_ch ();

  color_key_mask_closing_top u_top (
    .clk(clk), .rst(rst), .pix(pix_ch), .res(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow settings and closing state
  int unsigned key_b, key_g, key_r, tol_set, width_set, height_set;
  bit          mask_ring [NUM_STAGES][RING_LEN];
  int unsigned pos_count, col_pos, row_pos;
  bit          border_hit;

  mask_res_t   mask_expected [$];
  pixel_req_t  cur_req;
  int          n_errors, n_results, n_pixels, n_valid, n_rejected, n_frames;
  bit          hold_req, send_burst, recv_burst;

  function automatic longint clamp_dim(longint v, longint hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit chan_near(int unsigned pix, int unsigned key);
    int d;
    d = int'(pix) - int'(key);
    if (d < 0) d = -d;
    return d < int'(tol_set);
  endfunction

  // 3x3 dilation or erosion at position p, outside positions skipped
  function automatic bit window_val(int s, longint p, longint w, longint h);
    longint r, c, rr, cc;
    bit acc, v;
    r = p / w;
    c = p % w;
    acc = (s >= MORPH_PASSES);
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = r + dr;
        cc = c + dc;
        if (rr < 0 || rr >= h || cc < 0 || cc >= w) continue;
        v = mask_ring[s][(rr * w + cc) % RING_LEN];
        if (s < MORPH_PASSES) acc |= v;
        else acc &= v;
      end
    end
    return acc;
  endfunction

  function automatic mask_res_t close_mask(pixel_req_t q_in);
    mask_res_t res;
    longint w, h, n, t, q, p;
    bit v, have;
    w = clamp_dim(width_set, MAX_WIDTH);
    h = clamp_dim(height_set, MAX_HEIGHT);
    n = w * h;
    p = -1;
    if (q_in.first_pixel) begin
      pos_count = 0; col_pos = 0; row_pos = 0; border_hit = 0;
    end
    t = pos_count;
    v = 0;
    if (t < n && !q_in.flush && chan_near(q_in.blue, key_b) &&
        chan_near(q_in.green, key_g) && chan_near(q_in.red, key_r)) begin
      v = 1;
      if (col_pos == 0 || row_pos == 0 || row_pos == h - 1 || col_pos == w - 1)
        border_hit = 1;
    end
    have = 1;
    for (int s = 0; s < NUM_STAGES; s++) begin
      q = t - s * (w + 1);
      if (have && q >= 0 && q < n) mask_ring[s][q % RING_LEN] = v;
      p = q - (w + 1);
      if (p >= 0 && p < n) begin
        v = window_val(s, p, w, h);
        have = 1;
      end else begin
        v = 0;
        have = 0;
      end
    end
    res.out_valid  = have;
    res.mask_bit   = have & v;
    res.frame_last = have && p == n - 1;
    res.rejected   = border_hit;
    if (pos_count < CNT_MAX) pos_count++;
    if (t < n) begin
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1) & 12'hFFF;
      end
    end
    return res;
  endfunction

  // request and result monitor
  always @(posedge clk) begin
    mask_res_t got, exp_r;
    if (!rst) begin
      if (pix_ch.valid && pix_ch.ready) begin
        exp_r = close_mask(cur_req);
        mask_expected.push_back(cur_req.typed ? cur_req.want : exp_r);
      end
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.out_valid, res_ch.mask_bit, res_ch.frame_last, res_ch.rejected};
        n_results++;
        n_valid += got.out_valid;
        n_rejected += got.rejected;
        if (mask_expected.size() == 0) begin
          n_errors++;
          if (n_errors <= SHOW_ERRORS) $error("result with nothing outstanding");
        end else begin
          exp_r = mask_expected.pop_front();
          if (got.out_valid != exp_r.out_valid) begin
            n_errors++;
            if (n_errors <= SHOW_ERRORS)
              $error("out_valid expected %0d got %0d", exp_r.out_valid, got.out_valid);
          end
          if (got.mask_bit != exp_r.mask_bit) begin
            n_errors++;
            if (n_errors <= SHOW_ERRORS)
              $error("mask_bit expected %0d got %0d", exp_r.mask_bit, got.mask_bit);
          end
          if (got.frame_last != exp_r.frame_last) begin
            n_errors++;
            if (n_errors <= SHOW_ERRORS)
              $error("frame_last expected %0d got %0d", exp_r.frame_last, got.frame_last);
          end
          if (got.rejected != exp_r.rejected) begin
            n_errors++;
            if (n_errors <= SHOW_ERRORS)
              $error("rejected expected %0d got %0d", exp_r.rejected, got.rejected);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    int idle;
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
      idle = 0;
    else
      idle++;
    if (idle >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = recv_burst ? 0 : $urandom_range(0, 7);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 0;
      end else if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      @(negedge clk);
    end
  end

  task automatic apb_write(logic [REG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_KEY_BLUE:     key_b = val & 8'hFF;
      REG_KEY_GREEN:    key_g = val & 8'hFF;
      REG_KEY_RED:      key_r = val & 8'hFF;
      REG_TOLERANCE:    tol_set = val & 9'h1FF;
      REG_FRAME_WIDTH:  width_set = val & 11'h7FF;
      REG_FRAME_HEIGHT: height_set = val & 13'h1FFF;
      default: ;
    endcase
  endtask

  // stop offering, wait for every outstanding result, then let the pipeline go quiet
  task automatic drain_wait();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (mask_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_all(int unsigned kb, int unsigned kg, int unsigned kr,
                         int unsigned tl, int unsigned w, int unsigned h);
    drain_wait();
    apb_write(REG_KEY_BLUE, kb);
    apb_write(REG_KEY_GREEN, kg);
    apb_write(REG_KEY_RED, kr);
    apb_write(REG_TOLERANCE, tl);
    apb_write(REG_FRAME_WIDTH, w);
    apb_write(REG_FRAME_HEIGHT, h);
  endtask

  task automatic send_req(pixel_req_t rq);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_req = rq;
    pix_ch.blue <= rq.blue;
    pix_ch.green <= rq.green;
    pix_ch.red <= rq.red;
    pix_ch.first_pixel <= rq.first_pixel;
    pix_ch.flush <= rq.flush;
    pix_ch.valid <= 1'b1;
    do @(posedge clk); while (!pix_ch.ready);
    n_pixels++;
  endtask

  function automatic bit [7:0] near_chan(int unsigned key);
    int v, t;
    t = tol_set > 300 ? 300 : tol_set;
    case ($urandom_range(0, 3))
      0: v = int'(key) + t - 1;
      1: v = int'(key) - t;
      default: v = int'(key) + $urandom_range(0, 2 * t) - t;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic pixel_req_t rand_pixel(bit first);
    pixel_req_t rq;
    rq = '{default: 0};
    rq.first_pixel = first;
    rq.flush = ($urandom_range(0, 19) == 0);
    if ($urandom_range(0, 9) < 7) begin
      rq.blue = near_chan(key_b); rq.green = near_chan(key_g); rq.red = near_chan(key_r);
    end else begin
      rq.blue = 8'($urandom); rq.green = 8'($urandom); rq.red = 8'($urandom);
    end
    return rq;
  endfunction

  // one frame: pixels, then up to 6*(w+1) mostly flush requests to push out its tail
  task automatic run_frame(int unsigned cap);
    longint w, n, npix, tail;
    pixel_req_t rq;
    w = clamp_dim(width_set, MAX_WIDTH);
    n = w * clamp_dim(height_set, MAX_HEIGHT);
    npix = (cap != 0 && cap < n) ? cap : n;
    if ($urandom_range(0, 9) == 0) npix = $urandom_range(1, npix);
    send_burst = ($urandom_range(0, 3) == 0);
    recv_burst = ($urandom_range(0, 3) == 0);
    for (longint i = 0; i < npix; i++) send_req(rand_pixel(i == 0));
    tail = 6 * (w + 1);
    if (cap != 0 && tail > cap) tail = cap;
    if ($urandom_range(0, 7) == 0) tail = $urandom_range(0, tail);
    for (longint i = 0; i < tail; i++) begin
      rq = rand_pixel(0);
      rq.flush = (i >= 2) || npix < n || $urandom_range(0, 1);
      send_req(rq);
    end
    n_frames++;
  endtask

  // directed opening rows, default settings: nothing reaches the output yet
  pixel_req_t opening [] = '{
    '{8'd0,   8'd0,   8'd0,   0, 0, 1, '{0, 0, 0, 0}},
    '{8'd255, 8'd255, 8'd255, 0, 0, 1, '{0, 0, 0, 0}},
    '{8'd187, 8'd63,  8'd23,  0, 0, 1, '{0, 0, 0, 1}},
    '{8'd188, 8'd63,  8'd23,  0, 0, 1, '{0, 0, 0, 1}},
    '{8'd138, 8'd63,  8'd23,  0, 1, 1, '{0, 0, 0, 1}},
    '{8'd138, 8'd63,  8'd23,  1, 0, 1, '{0, 0, 0, 1}},
    '{8'd0,   8'd255, 8'd0,   1, 0, 1, '{0, 0, 0, 0}},
    '{8'd89,  8'd14,  8'd72,  0, 0, 1, '{0, 0, 0, 1}},
    '{8'd88,  8'd14,  8'd72,  0, 0, 0, '{0, 0, 0, 0}},
    '{8'd138, 8'd112, 8'd23,  0, 0, 0, '{0, 0, 0, 0}},
    '{8'd138, 8'd63,  8'd0,   0, 1, 0, '{0, 0, 0, 0}}
  };

  initial begin
    pix_ch.valid = 1'b0; pix_ch.blue = '0; pix_ch.green = '0; pix_ch.red = '0;
    pix_ch.first_pixel = 1'b0; pix_ch.flush = 1'b0;
    key_b = RST_KEY_BLUE; key_g = RST_KEY_GREEN; key_r = RST_KEY_RED;
    tol_set = RST_TOLERANCE; width_set = RST_WIDTH; height_set = RST_HEIGHT;
    pos_count = 0; col_pos = 0; row_pos = 0; border_hit = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_req(opening[i]);

    // extreme settings
    set_all(0, 0, 0, 0, 3, 3);
    repeat (3) run_frame(0);
    set_all(255, 255, 255, 256, 3, 3);
    repeat (3) run_frame(0);
    set_all(128, 0, 255, 511, 0, 0);
    repeat (2) run_frame(0);
    set_all(200, 40, 90, 60, 2, 2);
    repeat (2) run_frame(0);
    set_all(138, 63, 23, 50, 2047, 3);
    run_frame(100);
    set_all(10, 250, 120, 80, 4, 8191);
    run_frame(100);

    // long stall on the result side while requests keep coming
    set_all(90, 90, 90, 70, 6, 5);
    hold_req = 1;
    repeat (3) run_frame(0);

    // random settings, mostly small frames
    while (n_pixels < 1300) begin
      set_all($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 3) == 0 ? $urandom_range(0, 511) : $urandom_range(20, 120),
              $urandom_range(3, 10), $urandom_range(3, 8));
      repeat ($urandom_range(2, 5)) run_frame(0);
    end

    @(negedge clk);
    pix_ch.valid <= 1'b0;
    drain_wait();
    $display("%0d requests in %0d frames, %0d results (%0d carrying pixels, %0d rejected)",
             n_pixels, n_frames, n_results, n_valid, n_rejected);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ckmc_pkg.sv
rtl/ckmc_stream_if.sv
rtl/ckmc_regs.sv
rtl/ckmc_keyer.sv
rtl/ckmc_morph_stage.sv
rtl/color_key_mask_closing_top.sv
test/tb.sv
